// ===== rtl/core/stal_pkg.sv =====
// ----------------------------------------------------------------------------
// stal_pkg
// Shared sizes, codes and controller/datapath interface types for the
// self-organizing array list core.
// ----------------------------------------------------------------------------
package stal_pkg;

  localparam int CAPACITY    = 64;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  localparam int CMD_W       = 4;
  localparam int INDEX_W     = 6;
  localparam int WORD_W      = 32;
  localparam int TIMES_W     = 8;
  localparam int STATUS_W    = 3;
  localparam int POS_W       = 6;
  localparam int COUNT_W     = 7;
  localparam int TIMES_CNT_W = $clog2(TIMES_W);
  localparam int CMP_W       = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;

  // Input beat layout, lowest bit first: index, value, times, zero padding.
  localparam int IN_VALUE_LSB = INDEX_W;
  localparam int IN_TIMES_LSB = INDEX_W + WORD_W;
  localparam int IN_USED_W    = INDEX_W + WORD_W + TIMES_W;
  localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // Output beat layout, lowest bit first: status, data, position, count.
  localparam int OUT_DATA_LSB  = STATUS_W;
  localparam int OUT_POS_LSB   = STATUS_W + WORD_W;
  localparam int OUT_COUNT_LSB = STATUS_W + WORD_W + POS_W;
  localparam int OUT_USED_W    = STATUS_W + WORD_W + POS_W + COUNT_W;
  localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET            = 4'd0,
    CMD_SET            = 4'd1,
    CMD_FIND           = 4'd2,
    CMD_FRONT          = 4'd3,
    CMD_BACK           = 4'd4,
    CMD_PUSH           = 4'd5,
    CMD_INSERT         = 4'd6,
    CMD_ROTATE         = 4'd7,
    CMD_FIND_TRANSPOSE = 4'd8
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_INDEX = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_SCAN,
    S_SWAP_RD,
    S_SWAP_WR,
    S_SHIFT,
    S_INS_WR,
    S_DIV,
    S_ROT_CHK,
    S_ROT_A,
    S_ROT_GAP,
    S_ROT_B,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC,
    PTR_LAST,
    PTR_IDX
  } ptr_op_e;

  typedef enum logic [1:0] {
    WA_IDX,
    WA_LEN,
    WA_PTR,
    WA_PTR_NEXT
  } waddr_sel_e;

  typedef enum logic [1:0] {
    WD_VAL,
    WD_MAIN,
    WD_SCRATCH
  } wdata_sel_e;

  typedef struct packed {
    logic       load_in;
    ptr_op_e    ptr_op;
    logic       main_we;
    waddr_sel_e waddr_sel;
    wdata_sel_e wdata_sel;
    logic       scr_we;
    logic       wptr_rem;
    logic       wptr_step;
    logic       div_start;
    logic       div_step;
    logic       len_inc;
    logic       stage_we;
    status_e    stage_status;
    logic       stage_data;
    logic       stage_pos;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             idx_ok;
    logic             empty;
    logic             full;
    logic             at_last;
    logic             at_idx;
    logic             at_zero;
    logic             hit;
    logic             div_last;
    logic             rem_zero;
    logic             out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/stal_ram.sv =====
// ----------------------------------------------------------------------------
// stal_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module stal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/stal_ctrl.sv =====
// ----------------------------------------------------------------------------
// stal_ctrl
// Command sequencer: decodes each accepted command and steps the datapath
// through reads, searches, shifts and rotation passes.
// ----------------------------------------------------------------------------
module stal_ctrl
  import stal_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d            = state_q;
    in_ready_o         = 1'b0;
    cmd_o              = '0;
    cmd_o.ptr_op       = PTR_HOLD;
    cmd_o.waddr_sel    = WA_PTR;
    cmd_o.wdata_sel    = WD_VAL;
    cmd_o.stage_status = ST_OK;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DECODE;
        end
      end

      S_DECODE: begin
        state_d = S_DONE;
        unique case (stat_i.cmd) inside
          CMD_GET: begin
            if (stat_i.idx_ok) begin
              cmd_o.ptr_op = PTR_IDX;
              state_d      = S_READ;
            end else begin
              cmd_o.stage_we     = 1'b1;
              cmd_o.stage_status = ST_BAD_INDEX;
            end
          end
          CMD_SET: begin
            cmd_o.stage_we = 1'b1;
            if (stat_i.idx_ok) begin
              cmd_o.main_we   = 1'b1;
              cmd_o.waddr_sel = WA_IDX;
            end else begin
              cmd_o.stage_status = ST_BAD_INDEX;
            end
          end
          CMD_FIND, CMD_FIND_TRANSPOSE: begin
            if (stat_i.empty) begin
              cmd_o.stage_we     = 1'b1;
              cmd_o.stage_status = ST_NOT_FOUND;
            end else begin
              cmd_o.ptr_op = PTR_ZERO;
              state_d      = S_SCAN;
            end
          end
          CMD_FRONT, CMD_BACK: begin
            if (stat_i.empty) begin
              cmd_o.stage_we     = 1'b1;
              cmd_o.stage_status = ST_EMPTY;
            end else begin
              cmd_o.ptr_op = (stat_i.cmd == CMD_FRONT) ? PTR_ZERO : PTR_LAST;
              state_d      = S_READ;
            end
          end
          CMD_PUSH: begin
            cmd_o.stage_we = 1'b1;
            if (stat_i.full) begin
              cmd_o.stage_status = ST_FULL;
            end else begin
              cmd_o.main_we   = 1'b1;
              cmd_o.waddr_sel = WA_LEN;
              cmd_o.len_inc   = 1'b1;
            end
          end
          CMD_INSERT: begin
            if (!stat_i.idx_ok) begin
              cmd_o.stage_we     = 1'b1;
              cmd_o.stage_status = ST_BAD_INDEX;
            end else if (stat_i.full) begin
              cmd_o.stage_we     = 1'b1;
              cmd_o.stage_status = ST_FULL;
            end else begin
              cmd_o.ptr_op = PTR_LAST;
              state_d      = S_SHIFT;
            end
          end
          CMD_ROTATE: begin
            if (stat_i.empty) begin
              cmd_o.stage_we     = 1'b1;
              cmd_o.stage_status = ST_EMPTY;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = S_DIV;
            end
          end
          default: begin
            cmd_o.stage_we = 1'b1;
          end
        endcase
      end

      S_READ: begin
        cmd_o.stage_we   = 1'b1;
        cmd_o.stage_data = 1'b1;
        state_d          = S_DONE;
      end

      S_SCAN: begin
        if (stat_i.hit) begin
          if (stat_i.cmd == CMD_FIND) begin
            cmd_o.stage_we  = 1'b1;
            cmd_o.stage_pos = 1'b1;
            state_d         = S_DONE;
          end else if (stat_i.at_zero) begin
            cmd_o.stage_we = 1'b1;
            state_d        = S_DONE;
          end else begin
            cmd_o.ptr_op = PTR_DEC;
            state_d      = S_SWAP_RD;
          end
        end else if (stat_i.at_last) begin
          cmd_o.stage_we     = 1'b1;
          cmd_o.stage_status = ST_NOT_FOUND;
          state_d            = S_DONE;
        end else begin
          cmd_o.ptr_op = PTR_INC;
        end
      end

      S_SWAP_RD: begin
        cmd_o.main_we   = 1'b1;
        cmd_o.waddr_sel = WA_PTR_NEXT;
        cmd_o.wdata_sel = WD_MAIN;
        state_d         = S_SWAP_WR;
      end

      S_SWAP_WR: begin
        cmd_o.main_we   = 1'b1;
        cmd_o.stage_we  = 1'b1;
        cmd_o.stage_pos = 1'b1;
        state_d         = S_DONE;
      end

      S_SHIFT: begin
        cmd_o.main_we   = 1'b1;
        cmd_o.waddr_sel = WA_PTR_NEXT;
        cmd_o.wdata_sel = WD_MAIN;
        if (stat_i.at_idx) begin
          state_d = S_INS_WR;
        end else begin
          cmd_o.ptr_op = PTR_DEC;
        end
      end

      S_INS_WR: begin
        cmd_o.main_we  = 1'b1;
        cmd_o.len_inc  = 1'b1;
        cmd_o.stage_we = 1'b1;
        state_d        = S_DONE;
      end

      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_ROT_CHK;
        end
      end

      S_ROT_CHK: begin
        if (stat_i.rem_zero) begin
          cmd_o.stage_we = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd_o.wptr_rem = 1'b1;
          cmd_o.ptr_op   = PTR_ZERO;
          state_d        = S_ROT_A;
        end
      end

      S_ROT_A: begin
        cmd_o.scr_we    = 1'b1;
        cmd_o.wptr_step = 1'b1;
        if (stat_i.at_last) begin
          state_d = S_ROT_GAP;
        end else begin
          cmd_o.ptr_op = PTR_INC;
        end
      end

      S_ROT_GAP: begin
        cmd_o.ptr_op = PTR_ZERO;
        state_d      = S_ROT_B;
      end

      S_ROT_B: begin
        cmd_o.main_we   = 1'b1;
        cmd_o.wdata_sel = WD_SCRATCH;
        if (stat_i.at_last) begin
          cmd_o.stage_we = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd_o.ptr_op = PTR_INC;
        end
      end

      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/stal_dp.sv =====
// ----------------------------------------------------------------------------
// stal_dp
// Datapath: command registers, element count, list and scratch memories,
// address pointers, remainder unit and result registers.
// ----------------------------------------------------------------------------
module stal_dp
  import stal_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctrl_cmd_t              cmd_i,
  output dp_stat_t               stat_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [CMD_W-1:0]       s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [CMD_W-1:0]       op_q;
  logic [INDEX_W-1:0]     idx_q;
  logic [WORD_W-1:0]      val_q;
  logic [CNT_W-1:0]       len_q, len_d, len_last;
  logic [ADDR_W-1:0]      ptr_q, ptr_d, ptr_next;
  logic [ADDR_W-1:0]      wptr_q, wptr_d;
  logic [CNT_W-1:0]       rem_q, rem_d;
  logic [CNT_W:0]         rem_sh;
  logic [TIMES_W-1:0]     times_sh_q;
  logic [TIMES_CNT_W-1:0] div_cnt_q;

  logic                   main_we;
  logic [ADDR_W-1:0]      main_waddr;
  logic [WORD_W-1:0]      main_wdata, main_rdata, scr_rdata;

  status_e                stage_status_q, out_status_q;
  logic [WORD_W-1:0]      stage_data_q, out_data_q;
  logic [ADDR_W-1:0]      stage_pos_q, out_pos_q;
  logic [CNT_W-1:0]       out_count_q;
  logic                   out_valid_q, out_valid_d;

  assign len_last = len_q - 1'b1;
  assign ptr_next = ptr_q + 1'b1;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign len_d       = cmd_i.len_inc ? len_q + 1'b1 : len_q;
  assign out_valid_d = cmd_i.out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_comb begin
    unique case (cmd_i.ptr_op)
      PTR_HOLD: ptr_d = ptr_q;
      PTR_ZERO: ptr_d = '0;
      PTR_INC:  ptr_d = ptr_q + 1'b1;
      PTR_DEC:  ptr_d = ptr_q - 1'b1;
      PTR_LAST: ptr_d = ADDR_W'(len_last);
      PTR_IDX:  ptr_d = ADDR_W'(idx_q);
      default:  ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    if (cmd_i.wptr_rem) begin
      wptr_d = ADDR_W'(rem_q);
    end else if (cmd_i.wptr_step) begin
      wptr_d = (CNT_W'(wptr_q) == len_last) ? '0 : wptr_q + 1'b1;
    end else begin
      wptr_d = wptr_q;
    end
  end

  // One restoring step of times modulo length per cycle.
  assign rem_sh = {rem_q, times_sh_q[TIMES_W-1]};
  assign rem_d  = (rem_sh >= (CNT_W+1)'(len_q)) ? CNT_W'(rem_sh - (CNT_W+1)'(len_q))
                                                : CNT_W'(rem_sh);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q       <= s_axis_tuser;
      idx_q      <= s_axis_tdata[INDEX_W-1:0];
      val_q      <= s_axis_tdata[IN_VALUE_LSB +: WORD_W];
      times_sh_q <= s_axis_tdata[IN_TIMES_LSB +: TIMES_W];
    end else if (cmd_i.div_step) begin
      times_sh_q <= {times_sh_q[TIMES_W-2:0], 1'b0};
    end
    if (cmd_i.div_start) begin
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q     <= rem_d;
      div_cnt_q <= div_cnt_q + 1'b1;
    end
    ptr_q  <= ptr_d;
    wptr_q <= wptr_d;
    if (cmd_i.stage_we) begin
      stage_status_q <= cmd_i.stage_status;
      stage_data_q   <= cmd_i.stage_data ? main_rdata : '0;
      stage_pos_q    <= cmd_i.stage_pos ? ptr_q : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= stage_status_q;
      out_data_q   <= stage_data_q;
      out_pos_q    <= stage_pos_q;
      out_count_q  <= len_q;
    end
  end

  always_comb begin
    case (cmd_i.waddr_sel)
      WA_IDX:      main_waddr = ADDR_W'(idx_q);
      WA_LEN:      main_waddr = ADDR_W'(len_q);
      WA_PTR:      main_waddr = ptr_q;
      WA_PTR_NEXT: main_waddr = ptr_next;
      default:     main_waddr = ptr_q;
    endcase
    case (cmd_i.wdata_sel)
      WD_VAL:     main_wdata = val_q;
      WD_MAIN:    main_wdata = main_rdata;
      WD_SCRATCH: main_wdata = scr_rdata;
      default:    main_wdata = val_q;
    endcase
  end

  assign main_we = cmd_i.main_we;

  stal_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (main_we),
    .waddr_i (main_waddr),
    .wdata_i (main_wdata),
    .raddr_i (ptr_d),
    .rdata_o (main_rdata)
  );

  stal_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_scratch_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.scr_we),
    .waddr_i (wptr_q),
    .wdata_i (main_rdata),
    .raddr_i (ptr_d),
    .rdata_o (scr_rdata)
  );

  assign stat_o.cmd      = op_q;
  assign stat_o.idx_ok   = CMP_W'(idx_q) < CMP_W'(len_q);
  assign stat_o.empty    = (len_q == '0);
  assign stat_o.full     = (len_q >= CNT_W'(CAPACITY));
  assign stat_o.at_last  = (CNT_W'(ptr_q) == len_last);
  assign stat_o.at_idx   = (CMP_W'(ptr_q) == CMP_W'(idx_q));
  assign stat_o.at_zero  = (ptr_q == '0);
  assign stat_o.hit      = (main_rdata == val_q);
  assign stat_o.div_last = (div_cnt_q == TIMES_CNT_W'(TIMES_W - 1));
  assign stat_o.rem_zero = (rem_q == '0);
  assign stat_o.out_free = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({COUNT_W'(out_count_q),
                                       POS_W'(out_pos_q),
                                       out_data_q,
                                       out_status_q});

endmodule

// ===== rtl/core/search_transpose_array_list_core.sv =====
// ----------------------------------------------------------------------------
// search_transpose_array_list_core
// Fixed-capacity list of 32-bit words with get, set, find, front, back,
// push, insert, rotate and find-with-transpose commands, one result each.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Beat contents (lowest bit first)
//   s_axis    in         tdata: index, value, times; tuser: cmd
//   m_axis    out        tdata: status, data, position, count
//
// Get, front and back read one word, set and push write one, and flagged
// commands only report a status. Find walks one word per cycle, a transpose
// hit swaps with the word before, insert shifts the tail up a word at a time,
// and rotate takes times modulo length, then copies the list via scratch and
// back. Reset clears the count and the output valid flag, with no clearing
// pass. A new command is taken while a result waits; its own result then waits.
//
module search_transpose_array_list_core
  import stal_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // index, value, times, zero pad
  input  logic [CMD_W-1:0]       s_axis_tuser,   // cmd

  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // status, data, position, count
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  // The sequencer owns the input handshake and every step of a command.
  stal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  // The datapath holds the list, the pointers and the result registers, and
  // drives the output beat.
  stal_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .stat_o        (dp_stat),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
